>>> rtl/rscf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscf_pkg
// Shared types and constants for the region SAD compare and fill block.
// ----------------------------------------------------------------------------
package rscf_pkg;

  // default frame size
  localparam int DEF_IMG_W = 256;
  localparam int DEF_IMG_H = 256;

  // field widths
  localparam int CH_W      = 8;
  localparam int PIX_W     = 4 * CH_W;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_SAD_W = 26;
  localparam int PSAD_W    = 10;   // one pixel, four channels: at most 1020
  localparam int DIM_W     = 13;   // holds a frame dimension up to 4096

  localparam logic [OUT_SAD_W-1:0] SAD_MAX      = '1;
  localparam logic [PIX_W-1:0]     OPAQUE_BLACK = 32'hFF00_0000;
  localparam logic [CH_W-1:0]      ALPHA_OPAQUE = 8'hFF;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WORSE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

  // control from the sequencer to the accumulator unit
  typedef struct packed {
    logic clear;     // zero both sums
    logic px_vld;    // memory read data holds a pixel of the rectangle
  } acc_ctl_t;

endpackage
`default_nettype wire

>>> rtl/rscf_sad_acc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rscf_sad_acc
// Two-stage pixel SAD pipeline: per-pixel differences registered, then
// accumulated into the current and candidate sums.
// ----------------------------------------------------------------------------
module rscf_sad_acc #(
  parameter int ACC_W = 34
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  rscf_pkg::acc_ctl_t       ctl,
  input  wire [rscf_pkg::PIX_W-1:0] tgt_px,
  input  wire [rscf_pkg::PIX_W-1:0] apx_px,
  input  wire [rscf_pkg::PIX_W-1:0] col_px,
  output logic [ACC_W-1:0]         cur_sum,
  output logic [ACC_W-1:0]         cand_sum,
  output logic                     pend
);
  import rscf_pkg::*;

  // sum of absolute channel differences of two pixels
  function automatic logic [PSAD_W-1:0] px_sad(input logic [PIX_W-1:0] p,
                                               input logic [PIX_W-1:0] q);
    logic [PSAD_W-1:0] s;
    logic [CH_W-1:0]   u;
    logic [CH_W-1:0]   v;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      u = p[c*CH_W +: CH_W];
      v = q[c*CH_W +: CH_W];
      s = s + PSAD_W'((u > v) ? (u - v) : (v - u));
    end
    return s;
  endfunction

  logic [PSAD_W-1:0] psad_cur_r;
  logic [PSAD_W-1:0] psad_cand_r;
  logic              s2_vld_r;
  logic [ACC_W-1:0]  cur_r;
  logic [ACC_W-1:0]  cand_r;

  // per-pixel stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= ctl.px_vld;
    end
    psad_cur_r  <= px_sad(tgt_px, apx_px);
    psad_cand_r <= px_sad(tgt_px, col_px);
  end

  // accumulation stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cur_r  <= '0;
      cand_r <= '0;
    end else if (s2_vld_r) begin
      cur_r  <= cur_r + ACC_W'(psad_cur_r);
      cand_r <= cand_r + ACC_W'(psad_cand_r);
    end
  end

  assign cur_sum  = cur_r;
  assign cand_sum = cand_r;
  assign pend     = s2_vld_r;

endmodule
`default_nettype wire

>>> rtl/region_sad_compare_fill_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// region_sad_compare_fill_top
// Target and approximation images in two memories; proposals compare the
// rectangle SAD of the approximation against a flat colour and fill on win.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     start / busy      in_mode, in_pos_x, in_pos_y, in_rect_w/h, in_rgba
//  result    out_strobe        out_status, out_rgba, out_current/candidate_sad
//
//  load, mode 3, zero-size proposals and any out-of-frame item: the result is
//  registered on acceptance and busy stays low. read: busy for one cycle,
//  result on the following cycle. proposal: busy through the scan, the drain
//  of the sums and, when applied, the fill; the single read port of each memory
//  walks one pixel a cycle, then the fill walks the approximation write port
//  one pixel a cycle. after reset the approximation memory is swept to opaque
//  black, one pixel a cycle, with busy high. results cannot be stalled.
// ----------------------------------------------------------------------------
module region_sad_compare_fill_top #(
  parameter int IMG_W = rscf_pkg::DEF_IMG_W,
  parameter int IMG_H = rscf_pkg::DEF_IMG_H
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire [rscf_pkg::MODE_W-1:0]    in_mode,
  input  wire [7:0]                     in_pos_x,
  input  wire [7:0]                     in_pos_y,
  input  wire [8:0]                     in_rect_w,
  input  wire [8:0]                     in_rect_h,
  input  wire [rscf_pkg::CH_W-1:0]      in_red,
  input  wire [rscf_pkg::CH_W-1:0]      in_green,
  input  wire [rscf_pkg::CH_W-1:0]      in_blue,
  input  wire [rscf_pkg::CH_W-1:0]      in_alpha,
  output logic                          out_strobe,
  output logic [rscf_pkg::STAT_W-1:0]   out_status,
  output logic [rscf_pkg::CH_W-1:0]     out_red,
  output logic [rscf_pkg::CH_W-1:0]     out_green,
  output logic [rscf_pkg::CH_W-1:0]     out_blue,
  output logic [rscf_pkg::CH_W-1:0]     out_alpha,
  output logic [rscf_pkg::OUT_SAD_W-1:0] out_current_sad,
  output logic [rscf_pkg::OUT_SAD_W-1:0] out_candidate_sad
);
  import rscf_pkg::*;

  localparam int    NPIX    = IMG_W * IMG_H;
  localparam int    AW      = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam longint SUM_MAX = longint'(1020) * longint'(IMG_W) * longint'(IMG_H);
  localparam int    SUM_W   = $clog2(SUM_MAX + 1);
  localparam int    ACC_W   = (SUM_W > OUT_SAD_W) ? SUM_W : OUT_SAD_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FILL  = 6'b100000
  } state_t;

  // memories
  logic [PIX_W-1:0] tgt_mem [NPIX];
  logic [PIX_W-1:0] apx_mem [NPIX];

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]    start_r, start_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [8:0]       col_cnt_r, col_cnt_nxt;
  logic [8:0]       row_cnt_r, row_cnt_nxt;
  logic [8:0]       w_r, w_nxt;
  logic [8:0]       h_r, h_nxt;
  logic [PIX_W-1:0] col_r, col_nxt;
  logic             s1_r, s1_nxt;

  logic             res_strobe_r, res_strobe_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [PIX_W-1:0] res_px_r, res_px_nxt;
  logic [OUT_SAD_W-1:0] res_cur_r, res_cur_nxt;
  logic [OUT_SAD_W-1:0] res_cand_r, res_cand_nxt;

  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] tgt_q_r;
  logic [PIX_W-1:0] apx_q_r;
  logic             tgt_we;
  logic [AW-1:0]    tgt_waddr;
  logic [PIX_W-1:0] tgt_wdata;
  logic             apx_we;
  logic [AW-1:0]    apx_waddr;
  logic [PIX_W-1:0] apx_wdata;

  acc_ctl_t         acc_ctl;
  logic [ACC_W-1:0] cur_sum;
  logic [ACC_W-1:0] cand_sum;
  logic             sad_pend;

  logic             accept;
  logic [9:0]       x_end;
  logic [9:0]       y_end;
  logic             pix_ok;
  logic             rect_ok;
  logic [31:0]      pix_lin;
  logic [AW-1:0]    pix_addr;
  logic             col_last;
  logic             row_last;
  logic             walk_last;
  logic [AW-1:0]    walk_addr;
  logic [AW-1:0]    walk_base;
  logic [8:0]       walk_col;
  logic [8:0]       walk_row;
  logic [OUT_SAD_W-1:0] cur_sat;
  logic [OUT_SAD_W-1:0] cand_sat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // frame checks and linear pixel address
  assign x_end    = 10'(in_pos_x) + 10'(in_rect_w);
  assign y_end    = 10'(in_pos_y) + 10'(in_rect_h);
  assign pix_ok   = (DIM_W'(in_pos_x) < DIM_W'(IMG_W)) && (DIM_W'(in_pos_y) < DIM_W'(IMG_H));
  assign rect_ok  = (in_rect_w != 9'd0) && (in_rect_h != 9'd0) &&
                    (DIM_W'(x_end) <= DIM_W'(IMG_W)) && (DIM_W'(y_end) <= DIM_W'(IMG_H));
  assign pix_lin  = 32'(in_pos_y) * 32'(IMG_W) + 32'(in_pos_x);
  assign pix_addr = pix_lin[AW-1:0];

  // rectangle walk, raster order
  assign col_last  = (col_cnt_r == w_r - 9'd1);
  assign row_last  = (row_cnt_r == h_r - 9'd1);
  assign walk_last = col_last && row_last;
  always_comb begin
    if (col_last) begin
      walk_col  = 9'd0;
      walk_row  = row_cnt_r + 9'd1;
      walk_base = base_r + AW'(IMG_W);
      walk_addr = base_r + AW'(IMG_W);
    end else begin
      walk_col  = col_cnt_r + 9'd1;
      walk_row  = row_cnt_r;
      walk_base = base_r;
      walk_addr = addr_r + AW'(1);
    end
  end

  // saturated sums for reporting
  always_comb begin
    cur_sat  = (cur_sum > ACC_W'(SAD_MAX)) ? SAD_MAX : cur_sum[OUT_SAD_W-1:0];
    cand_sat = (cand_sum > ACC_W'(SAD_MAX)) ? SAD_MAX : cand_sum[OUT_SAD_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    start_nxt      = start_r;
    base_nxt       = base_r;
    addr_nxt       = addr_r;
    col_cnt_nxt    = col_cnt_r;
    row_cnt_nxt    = row_cnt_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    col_nxt        = col_r;
    s1_nxt         = 1'b0;
    res_strobe_nxt = 1'b0;
    res_status_nxt = res_status_r;
    res_px_nxt     = res_px_r;
    res_cur_nxt    = res_cur_r;
    res_cand_nxt   = res_cand_r;
    rd_addr        = addr_r;
    tgt_we         = 1'b0;
    tgt_waddr      = pix_addr;
    tgt_wdata      = {in_alpha, in_blue, in_green, in_red};
    apx_we         = 1'b0;
    apx_waddr      = addr_r;
    apx_wdata      = col_r;
    acc_ctl.clear  = 1'b0;
    acc_ctl.px_vld = s1_r;

    unique case (state_r)
      ST_CLEAR: begin
        apx_we       = 1'b1;
        apx_waddr    = clr_addr_r;
        apx_wdata    = OPAQUE_BLACK;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NPIX - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        rd_addr = pix_addr;
        if (accept) begin
          res_status_nxt = STAT_OK;
          res_px_nxt     = '0;
          res_cur_nxt    = '0;
          res_cand_nxt   = '0;
          unique case (in_mode)
            MODE_LOAD: begin
              res_strobe_nxt = 1'b1;
              if (pix_ok) begin
                tgt_we = 1'b1;
              end else begin
                res_status_nxt = STAT_INVALID;
              end
            end
            MODE_READ: begin
              if (pix_ok) begin
                state_nxt = ST_READ;
              end else begin
                res_strobe_nxt = 1'b1;
                res_status_nxt = STAT_INVALID;
              end
            end
            MODE_PROPOSE: begin
              if (rect_ok) begin
                acc_ctl.clear = 1'b1;
                start_nxt     = pix_addr;
                base_nxt      = pix_addr;
                addr_nxt      = pix_addr;
                col_cnt_nxt   = 9'd0;
                row_cnt_nxt   = 9'd0;
                w_nxt         = in_rect_w;
                h_nxt         = in_rect_h;
                col_nxt       = {ALPHA_OPAQUE, in_blue, in_green, in_red};
                state_nxt     = ST_SCAN;
              end else begin
                res_strobe_nxt = 1'b1;
                res_status_nxt = STAT_INVALID;
              end
            end
            MODE_NONE: begin
              res_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        res_strobe_nxt = 1'b1;
        res_px_nxt     = apx_q_r;
        state_nxt      = ST_IDLE;
      end

      // read both images over the rectangle
      ST_SCAN: begin
        rd_addr     = addr_r;
        s1_nxt      = 1'b1;
        addr_nxt    = walk_addr;
        base_nxt    = walk_base;
        col_cnt_nxt = walk_col;
        row_cnt_nxt = walk_row;
        if (walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end

      // wait for the sums, then decide
      ST_DRAIN: begin
        if (!s1_r && !sad_pend) begin
          res_cur_nxt  = cur_sat;
          res_cand_nxt = cand_sat;
          if (cand_sum < cur_sum) begin
            addr_nxt    = start_r;
            base_nxt    = start_r;
            col_cnt_nxt = 9'd0;
            row_cnt_nxt = 9'd0;
            state_nxt   = ST_FILL;
          end else begin
            res_strobe_nxt = 1'b1;
            res_status_nxt = STAT_WORSE;
            state_nxt      = ST_IDLE;
          end
        end
      end

      // write the colour over the rectangle
      ST_FILL: begin
        apx_we      = 1'b1;
        addr_nxt    = walk_addr;
        base_nxt    = walk_base;
        col_cnt_nxt = walk_col;
        row_cnt_nxt = walk_row;
        if (walk_last) begin
          res_strobe_nxt = 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      s1_r         <= 1'b0;
      res_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_r         <= s1_nxt;
      res_strobe_r <= res_strobe_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    base_r       <= base_nxt;
    addr_r       <= addr_nxt;
    col_cnt_r    <= col_cnt_nxt;
    row_cnt_r    <= row_cnt_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    col_r        <= col_nxt;
    res_status_r <= res_status_nxt;
    res_px_r     <= res_px_nxt;
    res_cur_r    <= res_cur_nxt;
    res_cand_r   <= res_cand_nxt;
  end

  // target image
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    tgt_q_r <= tgt_mem[rd_addr];
  end

  // approximation image
  always_ff @(posedge clk) begin
    if (apx_we) begin
      apx_mem[apx_waddr] <= apx_wdata;
    end
    apx_q_r <= apx_mem[rd_addr];
  end

  rscf_sad_acc #(
    .ACC_W (ACC_W)
  ) u_sad_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .tgt_px   (tgt_q_r),
    .apx_px   (apx_q_r),
    .col_px   (col_r),
    .cur_sum  (cur_sum),
    .cand_sum (cand_sum),
    .pend     (sad_pend)
  );

  assign out_strobe        = res_strobe_r;
  assign out_status        = res_status_r;
  assign out_red           = res_px_r[0*CH_W +: CH_W];
  assign out_green         = res_px_r[1*CH_W +: CH_W];
  assign out_blue          = res_px_r[2*CH_W +: CH_W];
  assign out_alpha         = res_px_r[3*CH_W +: CH_W];
  assign out_current_sad   = res_cur_r;
  assign out_candidate_sad = res_cand_r;

  // checks
  a_fill_only_on_win: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (cand_sum < cur_sum))
    else $error("fill running although candidate sum is not smaller");

  a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r || sad_pend) |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("sad pipeline active outside the scan");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (out_strobe && out_status == STAT_OK))
    else $error("read item did not produce its result");

  a_invalid_zero_sads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_INVALID) |->
      (out_current_sad == '0 && out_candidate_sad == '0))
    else $error("invalid item reported non-zero sums");

endmodule
`default_nettype wire
